FILE: design/sdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_pkg: shared types and constants of the switch debounce decoder
// Pin map, position codes and the decoded result record.
// ----------------------------------------------------------------------------
package sdd_pkg;

  localparam int SDD_PIN_W     = 9;
  localparam int SDD_CFG_W     = 8;
  localparam int SDD_WORD_W    = 10;
  localparam int SDD_COUNT_MAX = 255;

  localparam logic [SDD_CFG_W-1:0] SDD_DEBOUNCE_RST = 8'd2;

  // pin positions in a scan word
  localparam int PIN_SW1   = 0;
  localparam int PIN_SW2   = 1;
  localparam int PIN_SW3UP = 2;
  localparam int PIN_SW3DN = 3;
  localparam int PIN_SW4UP = 4;
  localparam int PIN_SW4DN = 5;
  localparam int PIN_OK    = 6;
  localparam int PIN_UP    = 7;
  localparam int PIN_DN    = 8;

  // three-position switch codes
  localparam logic [1:0] POS_UP  = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_DN  = 2'd2;

  typedef struct packed {
    logic                  switch_one;
    logic                  switch_two;
    logic [1:0]            switch_three;
    logic [1:0]            switch_four;
    logic [SDD_WORD_W-1:0] button_word;
    logic                  nav_ok;
    logic                  nav_up;
    logic                  nav_down;
  } sdd_result_t;

endpackage

FILE: design/sdd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_if: scan and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sdd_in_if;
  import sdd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SDD_PIN_W-1:0] pin_levels;

  modport source (output valid, output pin_levels, input ready);
  modport sink   (input valid, input pin_levels, output ready);
endinterface

interface sdd_out_if;
  import sdd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  switch_one;
  logic                  switch_two;
  logic [1:0]            switch_three;
  logic [1:0]            switch_four;
  logic [SDD_WORD_W-1:0] button_word;
  logic                  nav_ok;
  logic                  nav_up;
  logic                  nav_down;

  modport source (output valid, output switch_one, output switch_two,
                  output switch_three, output switch_four, output button_word,
                  output nav_ok, output nav_up, output nav_down, input ready);
  modport sink   (input valid, input switch_one, input switch_two,
                  input switch_three, input switch_four, input button_word,
                  input nav_ok, input nav_up, input nav_down, output ready);
endinterface

FILE: design/sdd_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_debounce: per-pin candidate level and saturating equal-scan counter
// Updates on each taken scan and exposes the stable levels after that scan.
// ----------------------------------------------------------------------------
module sdd_debounce #(
  parameter int COUNT_MAX = sdd_pkg::SDD_COUNT_MAX
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [sdd_pkg::SDD_PIN_W-1:0] pin_levels,
  input  logic [sdd_pkg::SDD_CFG_W-1:0] threshold,
  output logic [sdd_pkg::SDD_PIN_W-1:0] stable_nxt
);
  import sdd_pkg::*;

  localparam int CNT_W = $clog2(COUNT_MAX + 1);
  localparam int CMP_W = (CNT_W > SDD_CFG_W) ? CNT_W : SDD_CFG_W;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(COUNT_MAX);

  logic [SDD_PIN_W-1:0] stable_r, cand_r, pressed;
  logic [CNT_W-1:0]     cnt_r   [SDD_PIN_W];
  logic [CNT_W-1:0]     cnt_nxt [SDD_PIN_W];

  assign pressed = ~pin_levels;

  always_comb begin
    for (int i = 0; i < SDD_PIN_W; i++) begin
      if (pressed[i] == cand_r[i]) begin
        cnt_nxt[i] = (cnt_r[i] == CNT_SAT) ? cnt_r[i] : cnt_r[i] + CNT_W'(1);
      end else begin
        cnt_nxt[i] = '0;
      end
      // candidate always follows the new level
      if (CMP_W'(cnt_nxt[i]) >= CMP_W'(threshold)) begin
        stable_nxt[i] = pressed[i];
      end else begin
        stable_nxt[i] = stable_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '0;
      cand_r   <= '0;
      for (int i = 0; i < SDD_PIN_W; i++) cnt_r[i] <= CNT_SAT;
    end else if (take) begin
      stable_r <= stable_nxt;
      cand_r   <= pressed;
      for (int i = 0; i < SDD_PIN_W; i++) cnt_r[i] <= cnt_nxt[i];
    end
  end

endmodule

FILE: design/sdd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdd_decode: stable pin levels to switch positions and button word
// Up wins over down on three-position switches.
// ----------------------------------------------------------------------------
module sdd_decode (
  input  logic [sdd_pkg::SDD_PIN_W-1:0] stable,
  output sdd_pkg::sdd_result_t          result
);
  import sdd_pkg::*;

  logic [1:0] s3, s4;

  always_comb begin
    if (stable[PIN_SW3UP])      s3 = POS_UP;
    else if (stable[PIN_SW3DN]) s3 = POS_DN;
    else                        s3 = POS_MID;
    if (stable[PIN_SW4UP])      s4 = POS_UP;
    else if (stable[PIN_SW4DN]) s4 = POS_DN;
    else                        s4 = POS_MID;
  end

  always_comb begin
    result              = '0;
    result.switch_one   = stable[PIN_SW1];
    result.switch_two   = stable[PIN_SW2];
    result.switch_three = s3;
    result.switch_four  = s4;
    result.button_word[0] = ~stable[PIN_SW1];
    result.button_word[1] = stable[PIN_SW1];
    result.button_word[2] = ~stable[PIN_SW2];
    result.button_word[3] = stable[PIN_SW2];
    result.button_word[4] = (s3 == POS_UP);
    result.button_word[5] = (s3 == POS_MID);
    result.button_word[6] = (s3 == POS_DN);
    result.button_word[7] = (s4 == POS_UP);
    result.button_word[8] = (s4 == POS_MID);
    result.button_word[9] = (s4 == POS_DN);
    result.nav_ok   = stable[PIN_OK];
    result.nav_up   = stable[PIN_UP];
    result.nav_down = stable[PIN_DN];
  end

endmodule

FILE: design/switch_debounce_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_debounce_decoder_top: counter debouncer and decoder for nine pins
// One scan word in, one decoded result word out, one word per cycle unless the result stalls.
// ----------------------------------------------------------------------------
// Each scan word carries nine active-low pin levels (sw1, sw2, sw3 up/down,
// sw4 up/down, ok, up, down). A pin's level becomes stable once it has held
// for the configured threshold of further equal scans after the scan that
// changed it (0 makes it stable on that first scan). Every taken scan yields
// exactly one result word in the next cycle: switch positions, a ten-bit word of
// one-hot position groups and the three navigation buttons. The block takes a
// scan every cycle while the result is not stalled; the only stage is the result
// register, and a stalled result blocks input only while it is still waiting.
// After reset all pins read released, the counters sit saturated and the
// threshold is 2. Write cfg_wr_data with cfg_wr_en only while no scan is in flight.
// ----------------------------------------------------------------------------
module switch_debounce_decoder_top #(
  parameter int COUNT_MAX = sdd_pkg::SDD_COUNT_MAX
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sdd_in_if.sink                        in_port,
  sdd_out_if.source                     out_port,
  input  logic                          cfg_wr_en,
  input  logic [sdd_pkg::SDD_CFG_W-1:0] cfg_wr_data
);
  import sdd_pkg::*;

  // debounce threshold register
  logic [SDD_CFG_W-1:0] thresh_r;

  // result stage
  logic        out_valid_r;
  sdd_result_t out_r;

  logic                 in_fire;
  logic [SDD_PIN_W-1:0] stable_nxt;
  sdd_result_t          result_nxt;

  // new scan may enter when the result slot is empty or draining now
  assign in_port.ready = !out_valid_r || out_port.ready;
  assign in_fire       = in_port.valid && in_port.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= SDD_DEBOUNCE_RST;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // pin state updates only on a taken scan
  sdd_debounce #(
    .COUNT_MAX (COUNT_MAX)
  ) u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_fire),
    .pin_levels (in_port.pin_levels),
    .threshold  (thresh_r),
    .stable_nxt (stable_nxt)
  );

  // decode the levels as they stand after this scan
  sdd_decode u_decode (
    .stable (stable_nxt),
    .result (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= result_nxt;
    end
  end

  assign out_port.valid        = out_valid_r;
  assign out_port.switch_one   = out_r.switch_one;
  assign out_port.switch_two   = out_r.switch_two;
  assign out_port.switch_three = out_r.switch_three;
  assign out_port.switch_four  = out_r.switch_four;
  assign out_port.button_word  = out_r.button_word;
  assign out_port.nav_ok       = out_r.nav_ok;
  assign out_port.nav_up       = out_r.nav_up;
  assign out_port.nav_down     = out_r.nav_down;

  // a taken scan always shows up as a result on the next cycle
  a_fire_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_port.valid)
    else $error("taken scan produced no result");

  // each position group of the button word is one-hot
  a_word_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid |-> ($onehot(out_port.button_word[1:0]) &&
                        $onehot(out_port.button_word[3:2]) &&
                        $onehot(out_port.button_word[6:4]) &&
                        $onehot(out_port.button_word[9:7])))
    else $error("button word group not one-hot");

  // word bits 1, 5 and 9 agree with the switch fields
  a_word_matches : assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid |-> ((out_port.button_word[1] == out_port.switch_one) &&
                        (out_port.button_word[5] == (out_port.switch_three == POS_MID)) &&
                        (out_port.button_word[9] == (out_port.switch_four == POS_DN))))
    else $error("button word disagrees with switch fields");

endmodule
